### hdl/radix_integer_text_parser_top_macros.svh
// Assertion macros for the radix integer text parser.
// Used by radix_integer_text_parser_top; expects clk and arst_n in scope.
`ifndef RADIX_INTEGER_TEXT_PARSER_TOP_MACROS_SVH
`define RADIX_INTEGER_TEXT_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RTP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define RTP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/rtp_pkg.sv
// Shared types, constants and helpers for the radix integer text parser.
// No dependencies; imported by rtp_step and radix_integer_text_parser_top.
package rtp_pkg;

	localparam int unsigned MAX_CHARS_DEF = 4096;
	localparam int unsigned POS_W = 13;
	localparam int unsigned POS_CAP = 8191;
	localparam int unsigned BASE_W = 6;
	localparam logic [BASE_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [BASE_W-1:0] RADIX_AUTO = 6'd0;
	localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UX = 8'h58;
	localparam logic [7:0] NOT_DIGIT = 8'hFF;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_START,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} rtp_phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
	} rtp_in_item_t;

	typedef struct packed {
		logic signed [63:0] parsed_value;
		logic [POS_W-1:0]   stop_index;
	} rtp_out_item_t;

	// Parse state apart from the phase
	typedef struct packed {
		logic              negative_flag;
		logic [63:0]       accumulator;
		logic [BASE_W-1:0] active_base;
		logic [POS_W-1:0]  char_position;
		logic [POS_W-1:0]  stopped_position;
	} rtp_data_t;

	// Digit value 0..35 of a character, NOT_DIGIT otherwise
	function automatic logic [7:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		if (c >= CH_0 && c <= CH_9) begin
			d = c - CH_0;
		end else if (c >= CH_LA && c <= CH_LZ) begin
			d = c - CH_LA + 8'd10;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			d = c - CH_UA + 8'd10;
		end else begin
			d = NOT_DIGIT;
		end
		return d;
	endfunction

endpackage

### hdl/rtp_step.sv
// One parse step: phase transition and datapath update for one character.
// Depends on rtp_pkg; instantiated by radix_integer_text_parser_top.
module rtp_step #(
	parameter int unsigned MAX_CHARS = rtp_pkg::MAX_CHARS_DEF
) (
	input  rtp_pkg::rtp_phase_t         phase,
	input  rtp_pkg::rtp_data_t          data,
	input  logic [7:0]                  char_code,
	input  logic [rtp_pkg::BASE_W-1:0]  radix_mode,
	output rtp_pkg::rtp_phase_t         phase_nxt,
	output rtp_pkg::rtp_data_t          data_nxt,
	output rtp_pkg::rtp_out_item_t      result
);
	import rtp_pkg::*;

	localparam int unsigned POS_LIMIT = (MAX_CHARS < POS_CAP) ? MAX_CHARS : POS_CAP;
	localparam logic [POS_W-1:0] POS_LIMIT_V = POS_W'(POS_LIMIT);

	logic              is_space;
	logic              is_sign;
	logic              is_x;
	logic              start_zero;
	logic [BASE_W-1:0] start_base;
	logic [BASE_W-1:0] dig_base;
	logic [7:0]        dv;
	logic              dig_ok;
	logic [63:0]       mac;
	logic [POS_W-1:0]  pos_inc;

	// Classify the character
	always_comb begin
		is_space   = char_code inside {CH_SPACE, CH_TAB};
		is_sign    = char_code inside {CH_PLUS, CH_MINUS};
		is_x       = char_code inside {CH_LX, CH_UX};
		start_zero = (radix_mode == RADIX_AUTO || radix_mode == BASE_HEX) && char_code == CH_0;
		start_base = (radix_mode == RADIX_AUTO) ? BASE_DEC : radix_mode;
		dv         = digit_value(char_code);
	end

	// Base in effect for a digit taken in this step
	assign dig_base = (phase == PH_SPACE || phase == PH_START) ? start_base : data.active_base;
	assign dig_ok   = (dv != NOT_DIGIT) && (dv < {2'b00, dig_base});
	assign mac      = 64'(data.accumulator * 64'(dig_base)) + 64'(dv);
	assign pos_inc  = (data.char_position < POS_LIMIT_V) ? data.char_position + 1'b1
	                                                      : POS_LIMIT_V;

	// Next phase
	always_comb begin
		case (phase)
			PH_SPACE: begin
				if (is_space) begin
					phase_nxt = PH_SPACE;
				end else if (is_sign) begin
					phase_nxt = PH_START;
				end else if (start_zero) begin
					phase_nxt = PH_ZERO;
				end else begin
					phase_nxt = dig_ok ? PH_DIGITS : PH_DONE;
				end
			end
			PH_START: begin
				if (start_zero) begin
					phase_nxt = PH_ZERO;
				end else begin
					phase_nxt = dig_ok ? PH_DIGITS : PH_DONE;
				end
			end
			PH_ZERO: begin
				phase_nxt = (is_x || dig_ok) ? PH_DIGITS : PH_DONE;
			end
			PH_DIGITS: begin
				phase_nxt = dig_ok ? PH_DIGITS : PH_DONE;
			end
			PH_DONE: begin
				phase_nxt = PH_DONE;
			end
			default: begin
				phase_nxt = PH_SPACE;
			end
		endcase
	end

	// Datapath update
	always_comb begin
		data_nxt = data;
		data_nxt.char_position = pos_inc;
		case (phase)
			PH_SPACE, PH_START: begin
				if (phase == PH_SPACE && is_space) begin
					data_nxt.stopped_position = pos_inc;
				end else if (phase == PH_SPACE && is_sign) begin
					data_nxt.negative_flag    = (char_code == CH_MINUS);
					data_nxt.stopped_position = pos_inc;
				end else if (start_zero) begin
					data_nxt.active_base      = (radix_mode == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
					data_nxt.stopped_position = pos_inc;
				end else begin
					data_nxt.active_base = start_base;
					if (dig_ok) begin
						data_nxt.accumulator      = mac;
						data_nxt.stopped_position = pos_inc;
					end
				end
			end
			PH_ZERO: begin
				if (is_x) begin
					data_nxt.active_base      = BASE_HEX;
					data_nxt.stopped_position = pos_inc;
				end else if (dig_ok) begin
					data_nxt.accumulator      = mac;
					data_nxt.stopped_position = pos_inc;
				end
			end
			PH_DIGITS: begin
				if (dig_ok) begin
					data_nxt.accumulator      = mac;
					data_nxt.stopped_position = pos_inc;
				end
			end
			default: begin
				data_nxt.char_position = pos_inc;
			end
		endcase
	end

	// Result as it would leave on a final character
	assign result.parsed_value = data_nxt.negative_flag ? -$signed(data_nxt.accumulator)
	                                                    : $signed(data_nxt.accumulator);
	assign result.stop_index   = data_nxt.stopped_position;

endmodule

### hdl/radix_integer_text_parser_top.sv
// Radix integer text parser: takes one ASCII character per beat and, on the beat marked
// last, returns the signed 64-bit value and the index where scanning stopped (strtol rules:
// leading blanks, optional sign, base 0 detects 0x/0 prefixes, base 16 skips 0x). The block
// takes one character every cycle; a character is registered at acceptance and processed
// from that register by a single step of compares and a 64x6 multiply-add into the
// accumulator, which is the path that sets the clock. The step on the last character
// loads the result into an output register, where it sits while following characters
// keep flowing; input stalls only when a final character meets a held result. The radix
// register (cfg_data, reset 10) is always ready; the user must see that it is written
// between strings, which the block does not enforce. The base is fixed at the first
// character after blanks and sign. Positions saturate at min(MAX_CHARS, 8191).
module radix_integer_text_parser_top #(
	parameter int unsigned MAX_CHARS = rtp_pkg::MAX_CHARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          char_valid,
	output logic                          char_ready,
	input  rtp_pkg::rtp_in_item_t         char_item,
	output logic                          res_valid,
	input  logic                          res_ready,
	output rtp_pkg::rtp_out_item_t        res_item,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rtp_pkg::BASE_W-1:0]    cfg_data
);
	import rtp_pkg::*;

	localparam rtp_data_t DATA_RESET = '{
		negative_flag:    1'b0,
		accumulator:      64'd0,
		active_base:      '0,
		char_position:    '0,
		stopped_position: '0
	};

	logic              valid_s1;
	rtp_in_item_t      item_s1;
	logic [BASE_W-1:0] radix_q;
	rtp_phase_t        phase_q;
	rtp_data_t         data_q;
	logic              res_valid_q;
	rtp_out_item_t     res_item_q;

	rtp_phase_t        phase_nxt;
	rtp_data_t         data_nxt;
	rtp_out_item_t     step_result;
	logic              res_free;
	logic              adv_s1;

	// Handshake control
	assign res_free   = !res_valid_q || res_ready;
	assign adv_s1     = valid_s1 && (!item_s1.last_char || res_free);
	assign char_ready = !valid_s1 || adv_s1;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res_item   = res_item_q;

	// Hold the radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	// Input stage: capture one character beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			item_s1 <= char_item;
		end
	end

	rtp_step #(
		.MAX_CHARS(MAX_CHARS)
	) u_step (
		.phase      (phase_q),
		.data       (data_q),
		.char_code  (item_s1.char_code),
		.radix_mode (radix_q),
		.phase_nxt  (phase_nxt),
		.data_nxt   (data_nxt),
		.result     (step_result)
	);

	// Parse state: advance per character, rearm after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			data_q  <= DATA_RESET;
		end else if (adv_s1) begin
			if (item_s1.last_char) begin
				phase_q <= PH_SPACE;
				data_q  <= DATA_RESET;
			end else begin
				phase_q <= phase_nxt;
				data_q  <= data_nxt;
			end
		end
	end

	// Result register: load on the final character, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && item_s1.last_char) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_s1.last_char) begin
			res_item_q <= step_result;
		end
	end

`include "radix_integer_text_parser_top_macros.svh"

	`RTP_ASSERT_NEXT(a_rearm_after_last, adv_s1 && item_s1.last_char,
		res_valid_q && phase_q == PH_SPACE && data_q.char_position == '0,
		"parser did not rearm after final character")
	`RTP_ASSERT_NEXT(a_idle_state_hold, !valid_s1,
		$stable(data_q.char_position) && $stable(phase_q),
		"parse state moved without a character")
	`RTP_ASSERT_NOW(a_backpressure, valid_s1 && item_s1.last_char && !res_free,
		!char_ready && !adv_s1,
		"final character advanced over a held result")
	`RTP_ASSERT_NEXT(a_done_frozen, phase_q == PH_DONE && !(adv_s1 && item_s1.last_char),
		$stable(data_q.accumulator) && phase_q == PH_DONE,
		"accumulator changed after scanning stopped")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Testbench for radix_integer_text_parser_top: streams ASCII strings through the char channel
// and checks each parsed value and stop index against an in-bench parser model.
// Depends on rtp_pkg and radix_integer_text_parser_top only.
module testbench;
	import rtp_pkg::*;

	localparam int unsigned POS_LIMIT = (MAX_CHARS_DEF < POS_CAP) ? MAX_CHARS_DEF : POS_CAP;
	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_CHARS = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_ready;
	rtp_in_item_t char_item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	rtp_out_item_t res_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [BASE_W-1:0] cfg_data = '0;

	// Parser model state
	logic [BASE_W-1:0] radix_setting;
	rtp_phase_t scan_phase;
	logic scan_neg;
	logic [63:0] scan_acc;
	logic [BASE_W-1:0] scan_base;
	logic [POS_W-1:0] scan_pos;
	logic [POS_W-1:0] scan_stop;
	rtp_out_item_t expected_results[$];
	rtp_out_item_t want;

	// Stimulus and sink state
	logic [7:0] pending_text[$];
	logic [BASE_W-1:0] stim_radix;
	int chars_sent = 0;
	int errors = 0;
	bit source_steady = 1'b0;
	bit sink_steady = 1'b0;
	int sink_hold = 0;
	int sink_roll;

	radix_integer_text_parser_top #(
		.MAX_CHARS(MAX_CHARS_DEF)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item(res_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advance a position, saturating at the limit
	function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p);
		return (p < POS_LIMIT) ? p + 1'b1 : POS_W'(POS_LIMIT);
	endfunction

	// Value 0..35 of an alphanumeric character, -1 for anything else
	function automatic int alnum_weight(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
		if (c >= CH_LA && c <= CH_LZ) return int'(c) - int'(CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UZ) return int'(c) - int'(CH_UA) + 10;
		return -1;
	endfunction

	function automatic void clear_scan();
		scan_phase = PH_SPACE;
		scan_neg = 1'b0;
		scan_acc = '0;
		scan_base = '0;
		scan_pos = '0;
		scan_stop = '0;
	endfunction

	// Take one digit, or end the scan on a non-digit or out-of-base character
	function automatic void add_digit(input logic [7:0] c);
		int w;
		w = alnum_weight(c);
		if (w < 0 || w >= int'(scan_base)) begin
			scan_phase = PH_DONE;
		end else begin
			scan_acc = scan_acc * 64'(scan_base) + 64'(w);
			scan_stop = bump(scan_pos);
		end
	endfunction

	// Latch the base on the first character after blanks and sign
	function automatic void begin_number(input logic [7:0] c);
		if ((radix_setting == RADIX_AUTO || radix_setting == BASE_HEX) && c == CH_0) begin
			scan_base = (radix_setting == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
			scan_stop = bump(scan_pos);
			scan_phase = PH_ZERO;
		end else begin
			scan_base = (radix_setting == RADIX_AUTO) ? BASE_DEC : radix_setting;
			scan_phase = PH_DIGITS;
			add_digit(c);
		end
	endfunction

	// Step the model by one accepted beat; queue the result on the last one
	function automatic void parse_char(input rtp_in_item_t beat);
		logic [7:0] c;
		rtp_out_item_t res;
		c = beat.char_code;
		case (scan_phase)
			PH_SPACE: begin
				if (c == CH_SPACE || c == CH_TAB) begin
					scan_stop = bump(scan_pos);
				end else if (c == CH_MINUS || c == CH_PLUS) begin
					scan_neg = (c == CH_MINUS);
					scan_stop = bump(scan_pos);
					scan_phase = PH_START;
				end else begin
					begin_number(c);
				end
			end
			PH_START: begin
				begin_number(c);
			end
			PH_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					scan_base = BASE_HEX;
					scan_stop = bump(scan_pos);
					scan_phase = PH_DIGITS;
				end else begin
					scan_phase = PH_DIGITS;
					add_digit(c);
				end
			end
			PH_DIGITS: begin
				add_digit(c);
			end
			default: ;
		endcase
		scan_pos = bump(scan_pos);
		if (beat.last_char) begin
			res.parsed_value = scan_neg ? 64'd0 - scan_acc : scan_acc;
			res.stop_index = scan_stop;
			expected_results.push_back(res);
			clear_scan();
		end
	endfunction

	// Check results, track the radix register and step the model
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: result beat with no string pending: value %0d index %0d",
						$time, res_item.parsed_value, res_item.stop_index);
				end else begin
					want = expected_results.pop_front();
					if (res_item.parsed_value !== want.parsed_value) begin
						errors++;
						$display("%0t: parsed_value expected %0d got %0d",
							$time, want.parsed_value, res_item.parsed_value);
					end
					if (res_item.stop_index !== want.stop_index) begin
						errors++;
						$display("%0t: stop_index expected %0d got %0d",
							$time, want.stop_index, res_item.stop_index);
					end
				end
			end
			if (cfg_valid && cfg_ready) radix_setting = cfg_data;
			if (char_valid && char_ready) parse_char(char_item);
		end
	end

	// Drive res_ready: mostly ready, short stalls, an occasional long one
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			res_ready <= 1'b0;
		end else if (sink_steady) begin
			res_ready <= 1'b1;
		end else begin
			sink_roll = $urandom_range(0, 99);
			if (sink_roll < 65) begin
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b0;
				sink_hold = (sink_roll < 93) ? $urandom_range(0, 2) : $urandom_range(3, 30);
			end
		end
	end

	// Send one character beat after a random gap; valid stays high when no gap follows
	task automatic send_char(input logic [7:0] code, input logic fin);
		int gap;
		int roll;
		rtp_in_item_t beat;
		roll = $urandom_range(0, 99);
		if (source_steady || roll < 55) gap = 0;
		else if (roll < 92) gap = $urandom_range(1, 3);
		else gap = $urandom_range(4, 20);
		if (gap != 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		beat.char_code = code;
		beat.last_char = fin;
		char_item <= beat;
		char_valid <= 1'b1;
		do @(posedge clk); while (!char_ready);
		chars_sent++;
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) pending_text.push_back(s[i]);
	endfunction

	// Send the pending characters as one string, last flag on the final beat
	task automatic send_pending();
		int n;
		n = pending_text.size();
		for (int i = 0; i < n; i++) send_char(pending_text[i], i == n - 1);
		pending_text.delete();
	endtask

	task automatic parse_text(input string s);
		add_text(s);
		send_pending();
	endtask

	// Drain outstanding results, let the block settle, then write the radix
	task automatic write_radix(input logic [BASE_W-1:0] value);
		char_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		stim_radix = value;
	endtask

	function automatic logic [7:0] digit_char(input int w);
		if (w < 10) return CH_0 + 8'(w);
		return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(w - 10);
	endfunction

	// Build one string: mostly well-formed numbers, some pure noise
	function automatic void build_random_string();
		int roll;
		int eff;
		int lim;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			repeat ($urandom_range(1, 8)) pending_text.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 2))
			pending_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		case ($urandom_range(0, 3))
			0: pending_text.push_back(CH_MINUS);
			1: pending_text.push_back(CH_PLUS);
			default: ;
		endcase
		eff = (stim_radix == RADIX_AUTO) ? int'(BASE_DEC) : int'(stim_radix);
		if ((stim_radix == RADIX_AUTO || stim_radix == BASE_HEX)
				&& $urandom_range(0, 2) == 0) begin
			pending_text.push_back(CH_0);
			if ($urandom_range(0, 1)) begin
				pending_text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
				eff = int'(BASE_HEX);
			end else if (stim_radix == RADIX_AUTO) begin
				eff = int'(BASE_OCT);
			end
		end
		lim = (eff > 36) ? 36 : eff;
		repeat ($urandom_range(0, 22))
			pending_text.push_back(digit_char($urandom_range(0, lim - 1)));
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) pending_text.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Default radix 10: sign, blanks, no digits, NUL stop, 64-bit wrap
	task automatic test_decimal_defaults();
		parse_text("42");
		parse_text(" \t-17x");
		parse_text("+");
		parse_text("abc");
		add_text("12");
		pending_text.push_back(8'h00);
		add_text("3");
		send_pending();
		parse_text("18446744073709551617");
	endtask

	// Automatic base: hex and octal prefixes, bare prefix, lone zero
	task automatic test_auto_base();
		write_radix(RADIX_AUTO);
		parse_text("0x1F");
		parse_text("0Xg");
		parse_text("-017");
		parse_text("0");
		parse_text("089");
	endtask

	task automatic test_hex_base();
		write_radix(BASE_HEX);
		parse_text("0XfF");
		parse_text("-8000000000000000");
	endtask

	// Radix one, 36 and the 6-bit maximum
	task automatic test_radix_extremes();
		write_radix(6'd1);
		parse_text("001");
		write_radix(6'd36);
		parse_text("Zz");
		write_radix(6'd63);
		parse_text("zZ9");
	endtask

	// A radix write after the first digit must only affect the next string
	task automatic test_base_latch();
		write_radix(BASE_DEC);
		send_char(CH_SPACE, 1'b0);
		send_char(CH_0 + 8'd1, 1'b0);
		write_radix(BASE_HEX);
		parse_text("2f");
		parse_text("ff");
	endtask

	task automatic test_random_strings();
		int start;
		logic [BASE_W-1:0] r;
		start = chars_sent;
		while (chars_sent - start < RANDOM_CHARS) begin
			case ($urandom_range(0, 8))
				0: r = RADIX_AUTO;
				1: r = 6'd1;
				2: r = 6'd2;
				3: r = BASE_OCT;
				4: r = BASE_DEC;
				5: r = BASE_HEX;
				6: r = 6'd36;
				7: r = 6'd63;
				default: r = 6'($urandom_range(0, 63));
			endcase
			write_radix(r);
			source_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(6, 12)) begin
				build_random_string();
				send_pending();
			end
		end
	endtask

	initial begin
		radix_setting = RADIX_RESET;
		stim_radix = RADIX_RESET;
		clear_scan();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_decimal_defaults();
		test_auto_base();
		test_hex_base();
		test_radix_extremes();
		test_base_latch();
		test_random_strings();
		// Drain and let the pipeline go quiet
		char_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/rtp_pkg.sv
hdl/rtp_step.sv
hdl/radix_integer_text_parser_top.sv
test/testbench.sv
